FILE: rtl/brfp_pkg.sv
// shared types, codes and constants of the byte ring fifo with peek
package brfp_pkg;

  localparam int DEPTH_LOG2_DEF = 10;
  localparam int MAX_BURST_DEF  = 64;

  localparam int FUNC_W  = 2;
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 7;
  localparam int OFF_W   = 11;
  localparam int FILL_W  = 11;
  localparam int CAPL2_W = 4;

  localparam logic [CAPL2_W-1:0] CAPL2_RESET = 4'd10;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUT    = 2'd0,
    FUNC_GET    = 2'd1,
    FUNC_PEEK   = 2'd2,
    FUNC_RECORD = 2'd3
  } func_t;

  typedef struct packed {
    func_t              func;
    logic [BYTE_W-1:0]  put_byte;
    logic [LEN_W-1:0]   length;
    logic [OFF_W-1:0]   skip_offset;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  data_byte;
    logic               byte_valid;
    logic               accepted;
    logic [FILL_W-1:0]  fill_level;
    logic               last;
  } rsp_t;

endpackage

FILE: rtl/byte_ring_fifo_with_peek_unit.sv
// top level: byte ring fifo with put, get, peek and record get over one byte ram
//
// A byte fifo on a ram of 2**DEPTH_LOG2 bytes, of which 2**capacity_log2 are used
// as a ring. Writing cfg_wdata sets capacity_log2 (clamped to 1..DEPTH_LOG2 when
// used) and empties the buffer. A put, or any operation that returns no byte,
// gives one response beat. A get, peek or record get that returns n bytes (n up
// to MAX_BURST) gives n beats at one per cycle while the output is not stalled,
// set by the single read port of the ram: the item holds the block until its
// last byte is read, and only then is the next request taken. Output stalls
// stall the read stream with no loss. The ram has no reset and needs no clearing
// pass; reads never leave the stored data.
module byte_ring_fifo_with_peek_unit
  import brfp_pkg::*;
#(
  parameter int DEPTH_LOG2 = DEPTH_LOG2_DEF,
  parameter int MAX_BURST  = MAX_BURST_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CAPL2_W-1:0] cfg_wdata,
  input  logic               req_valid,
  output logic               req_ready,
  input  req_t               req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output rsp_t               rsp
);

  localparam int AW = DEPTH_LOG2;
  localparam int CW = DEPTH_LOG2 + 1;
  localparam int SW = (CW > 12) ? CW : 12;
  localparam int BW = $clog2(MAX_BURST + 1);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_STREAM = 2'b10
  } state_t;

  state_t state, state_next;

  logic [CAPL2_W-1:0] capacity_log2;
  logic [CW-1:0]      write_count, write_count_next;
  logic [CW-1:0]      read_count, read_count_next;
  logic [CW-1:0]      fill, fill_next;
  logic [AW-1:0]      ptr, ptr_next;
  logic [BW-1:0]      rem, rem_next;

  logic               stage_valid, stage_valid_next;
  logic               stage_bv, stage_bv_next;
  logic               stage_acc, stage_acc_next;
  logic [FILL_W-1:0]  stage_fill, stage_fill_next;
  logic               stage_last, stage_last_next;

  logic [4:0]         cap_eff;
  logic [AW-1:0]      addr_mask;
  logic [CW-1:0]      cap_bytes;

  logic               adv;
  logic               accept;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [BYTE_W-1:0]  ram_rdata;

  // clamped capacity and the ring address mask
  always_comb begin
    if (capacity_log2 == '0) begin
      cap_eff = 5'd1;
    end else if ({1'b0, capacity_log2} > 5'(DEPTH_LOG2)) begin
      cap_eff = 5'(DEPTH_LOG2);
    end else begin
      cap_eff = {1'b0, capacity_log2};
    end
    for (int i = 0; i < AW; i++) begin
      addr_mask[i] = (5'(i) < cap_eff);
    end
    cap_bytes = CW'(1) << cap_eff;
  end

  assign adv       = !stage_valid || rsp_ready;
  assign req_ready = (state == ST_IDLE) && adv;
  assign accept    = req_valid && req_ready;

  always_comb begin
    logic [BW-1:0] len_c;
    logic [SW-1:0] lvl_s;
    logic [SW-1:0] off_s;
    logic [SW-1:0] len_s;
    logic [SW-1:0] avail;
    logic [SW-1:0] need;
    logic [BW-1:0] n;
    logic [CW-1:0] f;

    len_c = (req.length > LEN_W'(MAX_BURST)) ? BW'(MAX_BURST) : BW'(req.length);
    lvl_s = SW'(fill);
    off_s = SW'(req.skip_offset);
    len_s = SW'(len_c);
    avail = lvl_s - off_s;
    need  = len_s + off_s;
    n     = '0;
    f     = fill;

    state_next       = state;
    write_count_next = write_count;
    read_count_next  = read_count;
    fill_next        = fill;
    ptr_next         = ptr;
    rem_next         = rem;
    stage_valid_next = stage_valid && !rsp_ready;
    stage_bv_next    = stage_bv;
    stage_acc_next   = stage_acc;
    stage_fill_next  = stage_fill;
    stage_last_next  = stage_last;
    ram_we           = 1'b0;
    ram_waddr        = AW'(write_count) & addr_mask;
    ram_re           = 1'b0;
    ram_raddr        = (AW'(read_count) + AW'(req.skip_offset)) & addr_mask;

    if (accept) begin
      stage_valid_next = 1'b1;
      stage_bv_next    = 1'b0;
      stage_acc_next   = 1'b1;
      stage_last_next  = 1'b1;
      unique case (req.func)
        FUNC_PUT: begin
          if (fill < cap_bytes) begin
            ram_we           = 1'b1;
            write_count_next = write_count + CW'(1);
            f                = fill + CW'(1);
          end else begin
            stage_acc_next = 1'b0;
          end
          fill_next = f;
        end
        FUNC_GET: begin
          ram_raddr       = AW'(read_count) & addr_mask;
          n               = (len_s < lvl_s) ? len_c : BW'(fill);
          f               = fill - CW'(n);
          fill_next       = f;
          read_count_next = read_count + CW'(n);
        end
        FUNC_PEEK: begin
          if (off_s < lvl_s) begin
            n = (avail < len_s) ? BW'(avail) : len_c;
          end
        end
        FUNC_RECORD: begin
          if (lvl_s < need) begin
            stage_acc_next = 1'b0;
          end else begin
            n               = len_c;
            f               = CW'(lvl_s - need);
            fill_next       = f;
            read_count_next = read_count + CW'(need);
          end
        end
        default: begin
        end
      endcase
      stage_fill_next = FILL_W'(f);
      if (n != '0) begin
        ram_re          = 1'b1;
        ptr_next        = ram_raddr + AW'(1);
        rem_next        = n - BW'(1);
        stage_bv_next   = 1'b1;
        stage_last_next = (n == BW'(1));
        if (n != BW'(1)) begin
          state_next = ST_STREAM;
        end
      end
    end else if (state == ST_STREAM && adv) begin
      // one byte per beat; fill and accepted stay as loaded at the start
      ram_re           = 1'b1;
      ram_raddr        = ptr & addr_mask;
      ptr_next         = ptr + AW'(1);
      rem_next         = rem - BW'(1);
      stage_valid_next = 1'b1;
      stage_bv_next    = 1'b1;
      stage_last_next  = (rem == BW'(1));
      if (rem == BW'(1)) begin
        state_next = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      capacity_log2 <= CAPL2_RESET;
      write_count   <= '0;
      read_count    <= '0;
      fill          <= '0;
      stage_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      stage_valid <= stage_valid_next;
      if (cfg_we) begin
        capacity_log2 <= cfg_wdata;
        write_count   <= '0;
        read_count    <= '0;
        fill          <= '0;
      end else begin
        write_count <= write_count_next;
        read_count  <= read_count_next;
        fill        <= fill_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    rem        <= rem_next;
    stage_bv   <= stage_bv_next;
    stage_acc  <= stage_acc_next;
    stage_fill <= stage_fill_next;
    stage_last <= stage_last_next;
  end

  brfp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (1 << DEPTH_LOG2)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (req.put_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rsp_valid       = stage_valid;
  assign rsp.data_byte   = stage_bv ? ram_rdata : '0;
  assign rsp.byte_valid  = stage_bv;
  assign rsp.accepted    = stage_acc;
  assign rsp.fill_level  = stage_fill;
  assign rsp.last        = stage_last;

endmodule

FILE: rtl/brfp_ram.sv
// generic single-port-write, single-port-read ram with registered read
module brfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
